[src/bs_pkg.sv]
// Package for the bubble sort block: sizes, the cell bundle, control and state types.
// Used by the channel interfaces, the sorting cell, the top level and the checker.
// No dependencies.
package bs_pkg;

   localparam int MAX_ITEMS  = 16;
   localparam int VALUE_BITS = 32;
   localparam int COUNT_BITS = $clog2(MAX_ITEMS + 1);

   // What one cell shows its neighbors.
   typedef struct packed {
      logic                  valid;
      logic                  lt;
      logic [VALUE_BITS-1:0] value;
   } bs_cell_type;

   // Commands broadcast to every cell of the row.
   typedef struct packed {
      logic insert;
      logic shift;
   } bs_ctl_type;

   typedef enum logic [0:0] {
      ST_FILL,
      ST_DRAIN
   } bs_state_type;

endpackage

[src/bs_channels.sv]
// Valid/ready channel interfaces for the element input and the sorted output.
// Depends on bs_pkg for the value width.
interface bs_req_if import bs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] value;
   logic                  last_item;

   modport source (output valid, output value, output last_item, input ready);
   modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface bs_rsp_if import bs_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [VALUE_BITS-1:0] sorted_value;
   logic                  run_end;
   logic                  overflow;

   modport source (output valid, output sorted_value, output run_end, output overflow,
                   input ready);
   modport sink   (input valid, input sorted_value, input run_end, input overflow,
                   output ready);
endinterface

[src/bs_cell.sv]
// One sorting cell: holds one element and its valid bit.
// Depends on bs_pkg for the cell bundle and control types.
module bs_cell import bs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  bs_ctl_type            ctl,
   input  logic [VALUE_BITS-1:0] insert_value,
   input  bs_cell_type           left,
   input  bs_cell_type           right,
   output bs_cell_type           self
);

   logic                  valid_ff, valid_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  lt;

   // An empty cell counts as holding plus infinity.
   assign lt = !valid_ff || ($signed(insert_value) < $signed(value_ff));

   always_comb begin
      valid_in = valid_ff;
      value_in = value_ff;
      if (ctl.shift) begin
         valid_in = right.valid;
         value_in = right.value;
      end else if (ctl.insert && lt) begin
         if (left.lt) begin
            // The new element lands further left; make room by taking the left value.
            valid_in = left.valid;
            value_in = left.value;
         end else begin
            valid_in = 1'b1;
            value_in = insert_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      value_ff <= value_in;
   end

   assign self = '{valid: valid_ff, lt: lt, value: value_ff};

endmodule

[src/bubble_sort_integers.sv]
// Top level of the signed integer sorter: a row of sorting cells and the fill/drain control.
// Depends on bs_pkg, the channel interfaces in bs_channels.sv and bs_cell.
//
// Elements arrive one per beat on req_chan; the beat that carries last_item closes the set.
// Every element is placed into its sorted position as it arrives: each cell compares the
// incoming value against its own element in the same cycle, and the row shifts right by one
// place from the insertion point, so the row is always in ascending signed order. Input is
// accepted at one beat per cycle while the set is filling. Up to MAX_ITEMS elements are kept;
// further elements of the same set are dropped and every result of that run carries overflow.
// In the cycle after the final element is accepted, the run appears on rsp_chan, smallest first,
// one beat per cycle when the sink is ready, taken from the first cell while the row shifts
// left; run_end marks the final beat. While the run is going out no input is accepted, and
// the output is read from the single read point at the head of the row. Equal values both
// appear in the run.
module bubble_sort_integers import bs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   bs_req_if.sink      req_chan,
   bs_rsp_if.source    rsp_chan
);

   bs_state_type          state_ff, state_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  dropped_ff, dropped_in;
   bs_ctl_type            ctl;
   logic                  req_beat;
   logic                  rsp_beat;
   logic                  full;

   bs_cell_type           cells [MAX_ITEMS];

   assign full     = (count_ff == COUNT_BITS'(MAX_ITEMS));
   assign req_beat = req_chan.valid && req_chan.ready;
   assign rsp_beat = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         count_ff   <= '0;
         dropped_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         dropped_ff <= dropped_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      ctl.insert     = 1'b0;
      ctl.shift      = 1'b0;
      req_chan.ready = 1'b0;
      rsp_chan.valid = 1'b0;
      case (state_ff)
         ST_FILL: begin
            req_chan.ready = 1'b1;
            if (req_beat) begin
               if (full) begin
                  dropped_in = 1'b1;
               end else begin
                  ctl.insert = 1'b1;
                  count_in   = count_ff + 1'b1;
               end
               if (req_chan.last_item) begin
                  state_in = ST_DRAIN;
               end
            end
         end
         ST_DRAIN: begin
            rsp_chan.valid = 1'b1;
            if (rsp_beat) begin
               ctl.shift = 1'b1;
               count_in  = count_ff - 1'b1;
               if (count_ff == COUNT_BITS'(1)) begin
                  dropped_in = 1'b0;
                  state_in   = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // The head of the row is the output register of the run.
   assign rsp_chan.sorted_value = cells[0].value;
   assign rsp_chan.run_end      = (count_ff == COUNT_BITS'(1));
   assign rsp_chan.overflow     = dropped_ff;

   localparam bs_cell_type EDGE_CELL = '{valid: 1'b0, lt: 1'b0, value: '0};

   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      bs_cell_type left_nb;
      bs_cell_type right_nb;

      if (i == 0) begin : g_head
         assign left_nb = EDGE_CELL;
      end else begin : g_mid_l
         assign left_nb = cells[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_tail
         assign right_nb = EDGE_CELL;
      end else begin : g_mid_r
         assign right_nb = cells[i+1];
      end

      bs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .ctl          (ctl),
         .insert_value (req_chan.value),
         .left         (left_nb),
         .right        (right_nb),
         .self         (cells[i])
      );
   end

endmodule

[src/bs_checker.sv]
// Port-level checker for bubble_sort_integers, attached by the bind at the end of this file.
// Depends on bs_pkg for the value width.
module bs_checker import bs_pkg::*; (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input logic                  req_last_item,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [VALUE_BITS-1:0] rsp_sorted_value,
   input logic                  rsp_run_end,
   input logic                  rsp_overflow
);

   logic                  have_prev_ff;
   logic [VALUE_BITS-1:0] prev_value_ff;
   logic                  rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff <= 1'b0;
      end else if (rsp_beat) begin
         have_prev_ff <= !rsp_run_end;
      end
      if (rsp_beat) begin
         prev_value_ff <= rsp_sorted_value;
      end
   end

   // Input and output never overlap: the set is either filling or draining.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a run is being sent");

   // The run starts right after the closing element.
   a_run_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_last_item) |=> rsp_valid)
      else $error("run did not start after the final element");

   // After the final beat of a run the block takes input again.
   a_run_closes: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_run_end) |=> (!rsp_valid && req_ready))
      else $error("block did not return to filling after the run");

   // Beats of one run come out in ascending signed order.
   a_ascending: assert property (@(posedge clock) disable iff (reset)
      (rsp_beat && have_prev_ff) |->
         ($signed(rsp_sorted_value) >= $signed(prev_value_ff)))
      else $error("run is not in ascending order");

   // A stalled result beat holds its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         ($stable(rsp_sorted_value) && $stable(rsp_run_end) && $stable(rsp_overflow)))
      else $error("stalled result beat changed");

endmodule

bind bubble_sort_integers bs_checker u_bs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_chan.valid),
   .req_ready        (req_chan.ready),
   .req_last_item    (req_chan.last_item),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_sorted_value (rsp_chan.sorted_value),
   .rsp_run_end      (rsp_chan.run_end),
   .rsp_overflow     (rsp_chan.overflow)
);
